[rtl/mpfb_pkg.sv]
// Package for the monochrome page frame store: request codes, panel command bytes,
// datapath operation codes and the command/status structs between controller and datapath.
// No dependencies.
package mpfb_pkg;

  localparam logic [2:0] REQ_DRAW      = 3'd0;
  localparam logic [2:0] REQ_PIC_START = 3'd1;
  localparam logic [2:0] REQ_PIC_BYTE  = 3'd2;
  localparam logic [2:0] REQ_CLEAR     = 3'd3;
  localparam logic [2:0] REQ_REFRESH   = 3'd4;

  localparam logic [7:0] CMD_PAGE_BASE = 8'hB0;
  localparam logic [7:0] CMD_COL_LO    = 8'h00;
  localparam logic [7:0] CMD_COL_HI    = 8'h10;
  localparam logic [7:0] PIX_BIT       = 8'h01;

  localparam logic [2:0] OP_IDLE  = 3'd0;
  localparam logic [2:0] OP_CLEAR = 3'd1;
  localparam logic [2:0] OP_PIX   = 3'd2;
  localparam logic [2:0] OP_BLT0  = 3'd3;
  localparam logic [2:0] OP_BLT1  = 3'd4;
  localparam logic [2:0] OP_EMIT  = 3'd5;

  typedef struct packed {
    logic       capture;
    logic       blit_start;
    logic       clr_start;
    logic       blit_adv;
    logic       emit_load;
    logic [2:0] op;
  } mpfb_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic left_zero;
    logic split;
  } mpfb_sts_t;

endpackage

[rtl/mpfb_if.sv]
// Valid/ready channel interfaces for requests and panel bytes.
// No dependencies.
interface mpfb_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] req_type;
  logic [6:0] x_pos;
  logic [4:0] y_pos;
  logic       pixel_on;
  logic [7:0] pic_width;
  logic [5:0] pic_height;
  logic       pic_mode;
  logic [7:0] data_byte;

  modport source (
    output valid, req_type, x_pos, y_pos, pixel_on, pic_width, pic_height, pic_mode,
    data_byte,
    input  ready
  );
  modport sink (
    input  valid, req_type, x_pos, y_pos, pixel_on, pic_width, pic_height, pic_mode,
    data_byte,
    output ready
  );
endinterface

interface mpfb_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       is_command;
  logic       frame_done;

  modport source (output valid, out_byte, is_command, frame_done, input ready);
  modport sink (input valid, out_byte, is_command, frame_done, output ready);
endinterface

[rtl/mpfb_dp.sv]
// Datapath: frame store RAM, picture blit registers, refresh scan registers,
// clear counter and output byte register. Depends on mpfb_pkg.
module mpfb_dp import mpfb_pkg::*; #(
  parameter int COLUMNS = 128,
  parameter int PAGES   = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic [2:0] req_type,
  input  logic [6:0] x_pos,
  input  logic [4:0] y_pos,
  input  logic       pixel_on,
  input  logic [7:0] pic_width,
  input  logic [5:0] pic_height,
  input  logic       pic_mode,
  input  logic [7:0] data_byte,
  input  mpfb_cmd_t  cmd,
  output mpfb_sts_t  sts,
  output logic [7:0] out_byte,
  output logic       is_command,
  output logic       frame_done
);

  localparam int STORE = COLUMNS * PAGES;
  localparam int AW    = $clog2(STORE);
  localparam int PGW   = (PAGES > 1) ? $clog2(PAGES) : 1;
  localparam int SPW   = $clog2(COLUMNS + 3);

  function automatic logic [AW-1:0] addr_of(input logic [4:0] page, input logic [8:0] col);
    logic [15:0] full;
    full = 16'(page) * 16'(COLUMNS) + 16'(col);
    return full[AW-1:0];
  endfunction

  logic [7:0]     frame_mem [STORE];
  logic [7:0]     rd_data_r;

  logic [6:0]     x_r;
  logic [4:0]     y_r;
  logic           on_r;
  logic [7:0]     db_r;

  logic [6:0]     bl_origin_r;
  logic [7:0]     bl_cursor_r;
  logic [6:0]     bl_row_r;
  logic [7:0]     bl_width_r;
  logic           bl_mode_r;
  logic [9:0]     bl_left_r;

  logic [PGW-1:0] sc_page_r;
  logic [SPW-1:0] sc_pos_r;
  logic [AW-1:0]  clr_cnt_r;

  logic [7:0]     out_byte_r;
  logic           is_cmd_r;
  logic           frame_done_r;

  logic [8:0]     bl_col;
  logic [4:0]     bl_p0;
  logic [4:0]     bl_p1;
  logic           bl_col_ok;
  logic [7:0]     bl_val;
  logic [15:0]    bl_data_w;
  logic [15:0]    bl_mask_w;
  logic [AW-1:0]  bl_addr0;
  logic [AW-1:0]  bl_addr1;
  logic [8:0]     cur_inc;

  logic [3:0]     pages_n;
  logic [11:0]    bytes_n;
  logic [9:0]     bytes_sat;

  logic [AW-1:0]  pix_addr_live;
  logic [AW-1:0]  pix_addr_lat;
  logic           pix_ok;
  logic [7:0]     pix_mask;
  logic [7:0]     pix_new;

  logic [SPW-1:0] sc_col;
  logic [AW-1:0]  sc_addr;
  logic           sc_is_cmd;
  logic           sc_last;
  logic           pg_last;
  logic [7:0]     sc_cmd_byte;

  logic [AW-1:0]  raddr;
  logic [AW-1:0]  waddr;
  logic [7:0]     wdata;
  logic           mem_we;

  assign bl_col    = 9'(bl_origin_r) + 9'(bl_cursor_r);
  assign bl_p0     = {1'b0, bl_row_r[6:3]};
  assign bl_p1     = bl_p0 + 5'd1;
  assign bl_col_ok = bl_col < 9'(COLUMNS);
  assign bl_val    = bl_mode_r ? db_r : ~db_r;
  assign bl_data_w = {8'h00, bl_val} << bl_row_r[2:0];
  assign bl_mask_w = 16'h00FF << bl_row_r[2:0];
  assign bl_addr0  = addr_of(bl_p0, bl_col);
  assign bl_addr1  = addr_of(bl_p1, bl_col);
  assign cur_inc   = 9'(bl_cursor_r) + 9'd1;

  assign pages_n   = 4'((7'(pic_height) + 7'd7) >> 3);
  assign bytes_n   = 12'(pic_width) * 12'(pages_n);
  assign bytes_sat = (bytes_n > 12'd1023) ? 10'd1023 : bytes_n[9:0];

  assign pix_addr_live = addr_of({3'b000, y_pos[4:3]}, {2'b00, x_pos});
  assign pix_addr_lat  = addr_of({3'b000, y_r[4:3]}, {2'b00, x_r});
  assign pix_ok        = ({2'b00, x_r} < 9'(COLUMNS)) && ({3'b000, y_r[4:3]} < 5'(PAGES));
  assign pix_mask      = PIX_BIT << y_r[2:0];
  assign pix_new       = on_r ? (rd_data_r | pix_mask) : (rd_data_r & ~pix_mask);

  assign sc_col    = sc_pos_r - SPW'(3);
  assign sc_addr   = addr_of(5'(sc_page_r), 9'(sc_col));
  assign sc_is_cmd = sc_pos_r < SPW'(3);
  assign sc_last   = sc_col == SPW'(COLUMNS - 1);
  assign pg_last   = sc_page_r == PGW'(PAGES - 1);

  always_comb begin
    if (sc_pos_r == SPW'(0)) begin
      sc_cmd_byte = CMD_PAGE_BASE + 8'(sc_page_r);
    end else if (sc_pos_r == SPW'(1)) begin
      sc_cmd_byte = CMD_COL_LO;
    end else begin
      sc_cmd_byte = CMD_COL_HI;
    end
  end

  always_comb begin
    raddr  = sc_addr;
    waddr  = clr_cnt_r;
    wdata  = 8'h00;
    mem_we = 1'b0;
    unique case (cmd.op)
      OP_IDLE: begin
        if (req_type == REQ_DRAW) begin
          raddr = pix_addr_live;
        end else if (req_type == REQ_PIC_BYTE) begin
          raddr = bl_addr0;
        end
      end
      OP_CLEAR: begin
        mem_we = 1'b1;
      end
      OP_PIX: begin
        mem_we = pix_ok;
        waddr  = pix_addr_lat;
        wdata  = pix_new;
      end
      OP_BLT0: begin
        raddr  = bl_addr1;
        mem_we = bl_col_ok && (bl_p0 < 5'(PAGES));
        waddr  = bl_addr0;
        wdata  = (rd_data_r & ~bl_mask_w[7:0]) | bl_data_w[7:0];
      end
      OP_BLT1: begin
        mem_we = bl_col_ok && (bl_p1 < 5'(PAGES));
        waddr  = bl_addr1;
        wdata  = (rd_data_r & ~bl_mask_w[15:8]) | bl_data_w[15:8];
      end
      default: begin
        raddr = sc_addr;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      frame_mem[waddr] <= wdata;
    end
    rd_data_r <= frame_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      x_r  <= x_pos;
      y_r  <= y_pos;
      on_r <= pixel_on;
      db_r <= data_byte;
    end
    if (cmd.emit_load) begin
      out_byte_r   <= sc_is_cmd ? sc_cmd_byte : rd_data_r;
      is_cmd_r     <= sc_is_cmd;
      frame_done_r <= !sc_is_cmd && sc_last && pg_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clr_start) begin
      clr_cnt_r <= '0;
    end else if (cmd.op == OP_CLEAR) begin
      clr_cnt_r <= clr_cnt_r + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bl_origin_r <= '0;
      bl_cursor_r <= '0;
      bl_row_r    <= '0;
      bl_width_r  <= '0;
      bl_mode_r   <= 1'b0;
      bl_left_r   <= '0;
    end else if (cmd.blit_start) begin
      bl_origin_r <= x_pos;
      bl_cursor_r <= '0;
      bl_row_r    <= {2'b00, y_pos};
      bl_width_r  <= pic_width;
      bl_mode_r   <= pic_mode;
      bl_left_r   <= bytes_sat;
    end else if (cmd.blit_adv) begin
      bl_left_r <= bl_left_r - 10'd1;
      if (cur_inc >= 9'(bl_width_r)) begin
        bl_cursor_r <= '0;
        bl_row_r    <= bl_row_r + 7'd8;
      end else begin
        bl_cursor_r <= cur_inc[7:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sc_page_r <= '0;
      sc_pos_r  <= '0;
    end else if (cmd.emit_load) begin
      if (sc_is_cmd || !sc_last) begin
        sc_pos_r <= sc_pos_r + SPW'(1);
      end else begin
        sc_pos_r  <= '0;
        sc_page_r <= pg_last ? '0 : sc_page_r + PGW'(1);
      end
    end
  end

  assign sts.clr_last  = clr_cnt_r == AW'(STORE - 1);
  assign sts.left_zero = bl_left_r == 10'd0;
  assign sts.split     = bl_row_r[2:0] != 3'd0;

  assign out_byte   = out_byte_r;
  assign is_command = is_cmd_r;
  assign frame_done = frame_done_r;

endmodule

[rtl/mpfb_ctrl.sv]
// Controller: request sequencing state machine and output valid flag.
// Drives mpfb_cmd_t to the datapath, reads mpfb_sts_t back. Depends on mpfb_pkg.
module mpfb_ctrl import mpfb_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [2:0] req_type,
  input  logic       out_ready,
  input  mpfb_sts_t  sts,
  output logic       in_ready,
  output logic       out_valid,
  output mpfb_cmd_t  cmd
);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_PIX   = 3'd2;
  localparam logic [2:0] ST_BLT0  = 3'd3;
  localparam logic [2:0] ST_BLT1  = 3'd4;
  localparam logic [2:0] ST_EMIT  = 3'd5;

  logic [2:0] state_r;
  logic [2:0] state_nxt;
  logic       out_valid_r;
  logic       accept;

  assign in_ready  = state_r == ST_IDLE;
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.op    = OP_IDLE;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.op = OP_CLEAR;
        if (sts.clr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          cmd.capture = 1'b1;
          unique case (req_type)
            REQ_DRAW:      state_nxt = ST_PIX;
            REQ_PIC_START: cmd.blit_start = 1'b1;
            REQ_PIC_BYTE: begin
              if (!sts.left_zero) begin
                state_nxt = ST_BLT0;
              end
            end
            REQ_CLEAR: begin
              cmd.clr_start = 1'b1;
              state_nxt     = ST_CLEAR;
            end
            REQ_REFRESH:   state_nxt = ST_EMIT;
            default:       state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_PIX: begin
        cmd.op    = OP_PIX;
        state_nxt = ST_IDLE;
      end
      ST_BLT0: begin
        cmd.op = OP_BLT0;
        if (sts.split) begin
          state_nxt = ST_BLT1;
        end else begin
          cmd.blit_adv = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      ST_BLT1: begin
        cmd.op       = OP_BLT1;
        cmd.blit_adv = 1'b1;
        state_nxt    = ST_IDLE;
      end
      ST_EMIT: begin
        cmd.op = OP_EMIT;
        if (!out_valid_r || out_ready) begin
          cmd.emit_load = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cmd.emit_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> state_r == ST_CLEAR)
    else $error("reset did not start the clearing pass");
  a_refresh_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && req_type == REQ_REFRESH) |=> state_r == ST_EMIT)
    else $error("refresh request did not reach emit");
  a_blt1_order: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_BLT1 |-> $past(state_r) == ST_BLT0)
    else $error("second page write without first");
  a_blt0_left: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_BLT0 |-> $past(sts.left_zero) == 1'b0)
    else $error("picture byte painted past picture end");
  a_emit_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT && out_valid_r && !out_ready) |=> state_r == ST_EMIT)
    else $error("refresh byte overwrote pending output");
`endif

endmodule

[rtl/mono_page_framebuffer_blit_scanout_core.sv]
// Monochrome page frame store with pixel draw, picture blit, clear and refresh stream.
// Requests are taken in idle, where the frame RAM read is issued; writes follow. A pixel
// rewrites its byte, picture start loads the blit registers, a picture byte writes one
// page or two if it spans two, a refresh byte loads the output register once it is free,
// and clear zeroes the RAM. After reset a clearing pass runs before requests are taken.
// Depends on mpfb_pkg, mpfb_if, mpfb_dp and mpfb_ctrl.
module mono_page_framebuffer_blit_scanout_core import mpfb_pkg::*; #(
  parameter int COLUMNS = 128,
  parameter int PAGES   = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  mpfb_in_if.sink     in_chan,
  mpfb_out_if.source  out_chan
);

  mpfb_cmd_t cmd;
  mpfb_sts_t sts;
  logic      in_ready;
  logic      out_valid;

  assign in_chan.ready  = in_ready;
  assign out_chan.valid = out_valid;

  mpfb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .req_type  (in_chan.req_type),
    .out_ready (out_chan.ready),
    .sts       (sts),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  mpfb_dp #(
    .COLUMNS (COLUMNS),
    .PAGES   (PAGES)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_type   (in_chan.req_type),
    .x_pos      (in_chan.x_pos),
    .y_pos      (in_chan.y_pos),
    .pixel_on   (in_chan.pixel_on),
    .pic_width  (in_chan.pic_width),
    .pic_height (in_chan.pic_height),
    .pic_mode   (in_chan.pic_mode),
    .data_byte  (in_chan.data_byte),
    .cmd        (cmd),
    .sts        (sts),
    .out_byte   (out_chan.out_byte),
    .is_command (out_chan.is_command),
    .frame_done (out_chan.frame_done)
  );

endmodule
